### design/lpl_pkg.sv
// Shared types and constants for the look-ahead peak limiter.
// Holds the word formats of the frame, result and register write channels.
// No dependencies.
package lpl_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int LEVEL_W    = 17;
    localparam int HOLD_W     = 10;
    localparam int COEF_W     = 16;
    localparam int CHAN_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;
    localparam int QUOT_W     = 34;
    localparam int DIV_STEPS  = QUOT_W / 2;
    localparam int GAIN_W     = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ATTACK    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS  = 3'd4;

    localparam logic [LEVEL_W-1:0] THRESHOLD_RST = 17'd65536;
    localparam logic [HOLD_W-1:0]  HOLD_RST      = 10'd48;
    localparam logic [COEF_W-1:0]  ATTACK_RST    = 16'd59000;
    localparam logic [COEF_W-1:0]  RELEASE_RST   = 16'd65400;
    localparam logic [CHAN_W-1:0]  CHANNELS_RST  = 2'd2;

    localparam logic [LEVEL_W-1:0] UNITY      = 17'd65536;
    localparam logic [34:0]        ROUND_HALF = 35'd32768;
    localparam logic [GAIN_W-1:0]  GAIN_CLAMP = 32'h8000_0000;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_ch0;
        logic signed [SAMPLE_W-1:0] sample_ch1;
        logic                       block_end;
    } t_frame;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] limited_ch0;
        logic signed [SAMPLE_W-1:0] limited_ch1;
        logic                       block_end_out;
    } t_result;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  reg_index;
        logic [CFG_DATA_W-1:0] reg_data;
    } t_cfg_word;

endpackage

### design/lpl_if.sv
// Valid/ready channel interfaces of the look-ahead peak limiter.
// Depends on lpl_pkg for the word formats.
interface lpl_frame_if;
    logic            valid;
    logic            ready;
    lpl_pkg::t_frame data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface lpl_result_if;
    logic             valid;
    logic             ready;
    lpl_pkg::t_result data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface lpl_cfg_if;
    logic               valid;
    logic               ready;
    lpl_pkg::t_cfg_word data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### design/lpl_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module lpl_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### design/lpl_div.sv
// Iterative restoring divider, two quotient bits per cycle, for the gain.
// Depends on lpl_pkg for the operand widths.
module lpl_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [lpl_pkg::QUOT_W-1:0]     i_dividend,
    input  logic [lpl_pkg::LEVEL_W-1:0]    i_divisor,
    output logic [lpl_pkg::QUOT_W-1:0]     o_quotient,
    output logic                           o_done
);

    localparam int CW = $clog2(lpl_pkg::DIV_STEPS);
    localparam logic [CW-1:0] LAST_STEP = CW'(lpl_pkg::DIV_STEPS - 1);

    logic                           r_busy;
    logic                           r_done;
    logic [CW-1:0]                  r_cnt;
    logic [lpl_pkg::QUOT_W-1:0]     r_num;
    logic [lpl_pkg::LEVEL_W-1:0]    r_rem;
    logic [lpl_pkg::LEVEL_W-1:0]    r_den;

    logic [lpl_pkg::LEVEL_W:0]      w_rem1;
    logic [lpl_pkg::LEVEL_W:0]      w_rem2;
    logic                           w_ge1;
    logic                           w_ge2;
    logic [lpl_pkg::LEVEL_W-1:0]    w_red1;
    logic [lpl_pkg::LEVEL_W-1:0]    w_red2;

    always_comb begin
        w_rem1 = {r_rem, r_num[lpl_pkg::QUOT_W-1]};
        w_ge1  = w_rem1 >= {1'b0, r_den};
        w_red1 = w_ge1 ? lpl_pkg::LEVEL_W'(w_rem1 - {1'b0, r_den})
                       : w_rem1[lpl_pkg::LEVEL_W-1:0];
        w_rem2 = {w_red1, r_num[lpl_pkg::QUOT_W-2]};
        w_ge2  = w_rem2 >= {1'b0, r_den};
        w_red2 = w_ge2 ? lpl_pkg::LEVEL_W'(w_rem2 - {1'b0, r_den})
                       : w_rem2[lpl_pkg::LEVEL_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_num  <= i_dividend;
                r_rem  <= '0;
                r_den  <= i_divisor;
            end else if (r_busy) begin
                r_num <= {r_num[lpl_pkg::QUOT_W-3:0], w_ge1, w_ge2};
                r_rem <= w_red2;
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_quotient = r_num;
    assign o_done     = r_done;

endmodule

### design/lookahead_peak_limiter.sv
// Top level of the look-ahead peak limiter: sequencer, envelope and output scaling.
// Depends on lpl_pkg, lpl_if, lpl_ram and lpl_div.
//
// Frames enter on i_frame and one result word per frame leaves on o_result, both
// valid/ready channels where a word moves at an edge with valid and ready high.
// Registers are written on i_cfg, which is always ready; index i selects register i.
// After reset the block clears both delay memories, one entry per cycle;
// i_frame is not ready during that pass.
// The divider forms the gain at two quotient bits per cycle. A new frame is
// accepted only once the sequencer is back in idle after the last one. The delay
// memory is read at one cycle and written the next, and the scaling shares one
// multiplier over both channels.
// The result sits in an output register; the next frame is accepted while it
// waits, and the sequencer holds its finished frame while the receiver stalls
// and the output register is still full.
module lookahead_peak_limiter #(
    parameter int DELAY_DEPTH  = 1024,
    parameter int MAX_CHANNELS = 2
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    lpl_cfg_if.sink       i_cfg,
    lpl_frame_if.sink     i_frame,
    lpl_result_if.source  o_result
);

    localparam int AW = $clog2(DELAY_DEPTH);
    localparam int RW = ((AW > lpl_pkg::HOLD_W) ? AW : lpl_pkg::HOLD_W) + 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(DELAY_DEPTH - 1);
    localparam logic [RW-1:0] DEPTH_X   = RW'(DELAY_DEPTH);
    localparam logic [31:0]   DEPTH_32  = 32'(DELAY_DEPTH);
    localparam logic [3:0]    MOD_LAST  = 4'(lpl_pkg::HOLD_W - 1);
    localparam logic [3:0]    MOD_STEPS = 4'(lpl_pkg::HOLD_W);

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_PEAK, ST_ENV1, ST_ENV2, ST_DIV,
        ST_RD, ST_WR, ST_SC0, ST_SC1, ST_FIN
    } t_state;

    t_state                               r_state;
    logic [AW-1:0]                        r_clr_addr;
    logic [lpl_pkg::LEVEL_W-1:0]          r_thr;
    logic [lpl_pkg::HOLD_W-1:0]           r_hold;
    logic [lpl_pkg::COEF_W-1:0]           r_att;
    logic [lpl_pkg::COEF_W-1:0]           r_rel;
    logic [lpl_pkg::CHAN_W-1:0]           r_chan;
    logic [lpl_pkg::HOLD_W-1:0]           r_timer;
    logic [lpl_pkg::LEVEL_W-1:0]          r_held;
    logic [lpl_pkg::LEVEL_W-1:0]          r_env;
    logic [AW-1:0]                        r_wr;
    logic [lpl_pkg::SAMPLE_W-1:0]         r_s0;
    logic [lpl_pkg::SAMPLE_W-1:0]         r_s1;
    logic                                 r_end;
    logic [32:0]                          r_prod;
    logic [lpl_pkg::COEF_W-1:0]           r_coef;
    logic [lpl_pkg::HOLD_W-1:0]           r_hmod;
    logic [3:0]                           r_mstep;
    logic [31:0]                          r_m0;
    logic [31:0]                          r_m1;
    logic                                 r_neg0;
    logic                                 r_neg1;
    logic                                 r_out_valid;
    lpl_pkg::t_result                     r_out;

    logic                                 w_two;
    logic [lpl_pkg::SAMPLE_W-1:0]         w_mag0;
    logic [lpl_pkg::SAMPLE_W-1:0]         w_mag1;
    logic [lpl_pkg::LEVEL_W-1:0]          w_key;
    logic [lpl_pkg::HOLD_W:0]             w_timer_inc;
    logic                                 w_renew;
    logic [lpl_pkg::COEF_W-1:0]           w_coef;
    logic [lpl_pkg::LEVEL_W-1:0]          w_ccomp;
    logic [34:0]                          w_sum;
    logic [lpl_pkg::LEVEL_W-1:0]          n_env;
    logic [lpl_pkg::LEVEL_W-1:0]          w_den;
    logic [31:0]                          w_mod_sub;
    logic                                 w_mod_ge;
    logic [RW-1:0]                        w_wr_x;
    logic [RW-1:0]                        w_hm_x;
    logic [RW-1:0]                        w_diff;
    logic [RW-1:0]                        w_wrap;
    logic [AW-1:0]                        w_rd_addr;
    logic [lpl_pkg::QUOT_W-1:0]           w_quot;
    logic                                 w_div_done;
    logic [lpl_pkg::GAIN_W-1:0]           w_gain;
    logic [lpl_pkg::SAMPLE_W-1:0]         w_dsel;
    logic [lpl_pkg::SAMPLE_W-1:0]         w_dmag;
    logic [47:0]                          w_scaled;
    logic                                 w_we0;
    logic                                 w_we1;
    logic [AW-1:0]                        w_waddr;
    logic [lpl_pkg::SAMPLE_W-1:0]         w_wdata0;
    logic [lpl_pkg::SAMPLE_W-1:0]         w_wdata1;
    logic                                 w_re;
    logic [lpl_pkg::SAMPLE_W-1:0]         w_rdata0;
    logic [lpl_pkg::SAMPLE_W-1:0]         w_rdata1;

    function automatic logic [lpl_pkg::SAMPLE_W-1:0] sat16(input logic neg,
                                                           input logic [31:0] m);
        logic [lpl_pkg::SAMPLE_W-1:0] res;
        if (neg) begin
            res = (m > 32'd32768) ? 16'h8000 : 16'(16'd0 - m[15:0]);
        end else begin
            res = (m > 32'd32767) ? 16'h7FFF : m[15:0];
        end
        return res;
    endfunction

    assign w_two = (r_chan >= 2'd2) && (MAX_CHANNELS >= 2);

    always_comb begin
        w_mag0 = r_s0[15] ? 16'(~r_s0 + 16'd1) : r_s0;
        w_mag1 = r_s1[15] ? 16'(~r_s1 + 16'd1) : r_s1;
        w_key  = {w_mag0, 1'b0};
        if (w_two && ({w_mag1, 1'b0} > w_key)) begin
            w_key = {w_mag1, 1'b0};
        end
        if (w_key < r_thr) begin
            w_key = r_thr;
        end
        w_timer_inc = {1'b0, r_timer} + 11'd1;
        w_renew     = (w_timer_inc >= {1'b0, r_hold}) || (w_key > r_held);
    end

    always_comb begin
        w_coef  = (r_held > r_env) ? r_att : r_rel;
        w_ccomp = lpl_pkg::LEVEL_W'(lpl_pkg::UNITY - {1'b0, r_coef});
        w_sum   = 35'(r_prod) + 35'(w_ccomp) * 35'(r_held) + lpl_pkg::ROUND_HALF;
        n_env   = w_sum[32:16];
        w_den   = (n_env == '0) ? 17'd1 : n_env;
    end

    always_comb begin
        w_mod_sub = DEPTH_32 << (MOD_LAST - r_mstep);
        w_mod_ge  = 32'(r_hmod) >= w_mod_sub;
        w_wr_x    = RW'(r_wr);
        w_hm_x    = RW'(r_hmod);
        w_diff    = w_wr_x - w_hm_x;
        w_wrap    = w_diff + DEPTH_X;
        w_rd_addr = (w_wr_x >= w_hm_x) ? w_diff[AW-1:0] : w_wrap[AW-1:0];
    end

    always_comb begin
        w_gain   = (w_quot >= lpl_pkg::QUOT_W'(lpl_pkg::GAIN_CLAMP)) ? lpl_pkg::GAIN_CLAMP
                                                                     : w_quot[31:0];
        w_dsel   = (r_state == ST_SC1) ? w_rdata1 : w_rdata0;
        w_dmag   = w_dsel[15] ? 16'(~w_dsel + 16'd1) : w_dsel;
        w_scaled = 48'(w_dmag) * 48'(w_gain);
    end

    always_comb begin
        w_we0    = (r_state == ST_CLEAR) || (r_state == ST_WR);
        w_we1    = (r_state == ST_CLEAR) || ((r_state == ST_WR) && w_two);
        w_waddr  = (r_state == ST_CLEAR) ? r_clr_addr : r_wr;
        w_wdata0 = (r_state == ST_CLEAR) ? '0 : r_s0;
        w_wdata1 = (r_state == ST_CLEAR) ? '0 : r_s1;
        w_re     = (r_state == ST_RD);
    end

    lpl_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == ST_ENV2),
        .i_dividend ({1'b0, r_thr, 16'd0}),
        .i_divisor  (w_den),
        .o_quotient (w_quot),
        .o_done     (w_div_done)
    );

    lpl_ram #(
        .WIDTH (lpl_pkg::SAMPLE_W),
        .DEPTH (DELAY_DEPTH)
    ) u_ram_ch0 (
        .i_clk   (i_clk),
        .i_we    (w_we0),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata0),
        .i_re    (w_re),
        .i_raddr (w_rd_addr),
        .o_rdata (w_rdata0)
    );

    generate
        if (MAX_CHANNELS >= 2) begin : g_ch1
            lpl_ram #(
                .WIDTH (lpl_pkg::SAMPLE_W),
                .DEPTH (DELAY_DEPTH)
            ) u_ram_ch1 (
                .i_clk   (i_clk),
                .i_we    (w_we1),
                .i_waddr (w_waddr),
                .i_wdata (w_wdata1),
                .i_re    (w_re),
                .i_raddr (w_rd_addr),
                .o_rdata (w_rdata1)
            );
        end else begin : g_no_ch1
            assign w_rdata1 = '0;
        end
    endgenerate

    assign i_cfg.ready    = 1'b1;
    assign i_frame.ready  = (r_state == ST_IDLE);
    assign o_result.valid = r_out_valid;
    assign o_result.data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_thr       <= lpl_pkg::THRESHOLD_RST;
            r_hold      <= lpl_pkg::HOLD_RST;
            r_att       <= lpl_pkg::ATTACK_RST;
            r_rel       <= lpl_pkg::RELEASE_RST;
            r_chan      <= lpl_pkg::CHANNELS_RST;
            r_timer     <= '0;
            r_held      <= lpl_pkg::THRESHOLD_RST;
            r_env       <= lpl_pkg::THRESHOLD_RST;
            r_wr        <= '0;
            r_mstep     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                case (i_cfg.data.reg_index)
                    lpl_pkg::CFG_THRESHOLD: r_thr  <= i_cfg.data.reg_data;
                    lpl_pkg::CFG_HOLD:      r_hold <= i_cfg.data.reg_data[9:0];
                    lpl_pkg::CFG_ATTACK:    r_att  <= i_cfg.data.reg_data[15:0];
                    lpl_pkg::CFG_RELEASE:   r_rel  <= i_cfg.data.reg_data[15:0];
                    lpl_pkg::CFG_CHANNELS:  r_chan <= i_cfg.data.reg_data[1:0];
                    default: ;
                endcase
            end
            if (r_out_valid && o_result.ready && (r_state != ST_FIN)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == LAST_ADDR) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (i_frame.valid) begin
                        r_s0    <= i_frame.data.sample_ch0;
                        r_s1    <= i_frame.data.sample_ch1;
                        r_end   <= i_frame.data.block_end;
                        r_state <= ST_PEAK;
                    end
                end
                ST_PEAK: begin
                    if (w_renew) begin
                        r_timer <= '0;
                        r_held  <= w_key;
                    end else begin
                        r_timer <= w_timer_inc[lpl_pkg::HOLD_W-1:0];
                    end
                    r_state <= ST_ENV1;
                end
                ST_ENV1: begin
                    r_coef  <= w_coef;
                    r_prod  <= 33'(w_coef) * 33'(r_env);
                    r_state <= ST_ENV2;
                end
                ST_ENV2: begin
                    r_env   <= n_env;
                    r_hmod  <= r_hold;
                    r_mstep <= '0;
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    if (r_mstep < MOD_STEPS) begin
                        r_mstep <= r_mstep + 1'b1;
                        if (w_mod_ge) begin
                            r_hmod <= r_hmod - w_mod_sub[lpl_pkg::HOLD_W-1:0];
                        end
                    end
                    if (w_div_done) begin
                        r_state <= ST_RD;
                    end
                end
                ST_RD: begin
                    r_state <= ST_WR;
                end
                ST_WR: begin
                    r_wr    <= (r_wr == LAST_ADDR) ? '0 : r_wr + 1'b1;
                    r_state <= ST_SC0;
                end
                ST_SC0: begin
                    r_m0    <= w_scaled[47:16];
                    r_neg0  <= w_rdata0[15];
                    r_state <= ST_SC1;
                end
                ST_SC1: begin
                    r_m1    <= w_scaled[47:16];
                    r_neg1  <= w_rdata1[15];
                    r_state <= ST_FIN;
                end
                ST_FIN: begin
                    if (!r_out_valid || o_result.ready) begin
                        r_out.limited_ch0   <= sat16(r_neg0, r_m0);
                        r_out.limited_ch1   <= w_two ? sat16(r_neg1, r_m1) : '0;
                        r_out.block_end_out <= r_end;
                        r_out_valid         <= 1'b1;
                        r_state             <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_env_between: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(r_state == ST_ENV2) |->
            ((r_env >= $past(r_env) && r_env <= $past(r_held)) ||
             (r_env <= $past(r_env) && r_env >= $past(r_held))))
        else $error("Envelope left the span between old envelope and held peak.");

    a_offset_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RD) |-> (32'(r_hmod) < DEPTH_32))
        else $error("Delay offset not reduced below the memory depth.");

    a_read_after_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RD) |-> $past(w_div_done))
        else $error("Delay read issued before the gain was ready.");

    a_result_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == ST_FIN))
        else $error("Result word appeared outside the finish step.");

    a_fin_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FIN && r_out_valid && !o_result.ready) |=> (r_state == ST_FIN))
        else $error("Finished frame dropped while the output register was full.");
`endif

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for lookahead_peak_limiter: directed and random frames under many
// register settings, checked word by word against a built-in limiter predictor.
// Depends on lpl_pkg, lpl_if and the limiter RTL.
module tb_top;

    localparam int DEPTH          = 1024;
    localparam int HALF_PERIOD    = 6;
    localparam int TIMEOUT_CYCLES = 1_000_000;

    localparam logic [lpl_pkg::CFG_IDX_W-1:0] CFG_FIRST_UNUSED = 3'd5;

    typedef enum int {SIG_SILENT, SIG_QUIET, SIG_MODERATE, SIG_EXTREME, SIG_NOISE} t_signal;
    typedef enum int {RX_OPEN, RX_SPARSE, RX_COIN, RX_BLOCKED} t_rx_mode;

    logic i_clk;
    logic i_rst_n;

    lpl_cfg_if    cfg_bus ();
    lpl_frame_if  frame_bus ();
    lpl_result_if result_bus ();

    lookahead_peak_limiter #(
        .DELAY_DEPTH  (DEPTH),
        .MAX_CHANNELS (2)
    ) i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg_bus),
        .i_frame  (frame_bus),
        .o_result (result_bus)
    );

    logic [lpl_pkg::LEVEL_W-1:0]  thr_level;
    logic [lpl_pkg::HOLD_W-1:0]   hold_len;
    logic [lpl_pkg::COEF_W-1:0]   attack_pole;
    logic [lpl_pkg::COEF_W-1:0]   release_pole;
    logic [lpl_pkg::CHAN_W-1:0]   chan_sel;
    logic [lpl_pkg::HOLD_W-1:0]   hold_count;
    logic [lpl_pkg::LEVEL_W-1:0]  held_level;
    logic [lpl_pkg::LEVEL_W-1:0]  env_level;
    logic [$clog2(DEPTH)-1:0]     wr_pos;
    logic [lpl_pkg::SAMPLE_W-1:0] line0 [DEPTH];
    logic [lpl_pkg::SAMPLE_W-1:0] line1 [DEPTH];

    lpl_pkg::t_frame  pending_frames [$];
    lpl_pkg::t_result limited_words [$];
    lpl_pkg::t_result due_word;
    t_rx_mode         rx_mode;

    int frames_queued;
    int frames_accepted;
    int results_seen;
    int err_count;
    int settings_applied;
    int burst_left;
    int gap_left;
    int rx_count;

    always begin
        i_clk = 1'b0;
        #HALF_PERIOD;
        i_clk = 1'b1;
        #HALF_PERIOD;
    end

    function automatic logic [lpl_pkg::SAMPLE_W-1:0] apply_gain(
            input logic [lpl_pkg::SAMPLE_W-1:0] raw, input logic [63:0] gain);
        logic [lpl_pkg::SAMPLE_W-1:0] mag;
        logic [63:0]                  prod;
        mag  = raw[lpl_pkg::SAMPLE_W-1] ? -raw : raw;
        prod = (64'(mag) * gain) >> 16;
        if (raw[lpl_pkg::SAMPLE_W-1])
            return (prod > 64'd32768) ? 16'h8000 : 16'(64'd0 - prod);
        return (prod > 64'd32767) ? 16'h7fff : prod[lpl_pkg::SAMPLE_W-1:0];
    endfunction

    task automatic compute_limited(input lpl_pkg::t_frame f);
        logic                         two;
        logic [lpl_pkg::SAMPLE_W-1:0] mag0;
        logic [lpl_pkg::SAMPLE_W-1:0] mag1;
        logic [lpl_pkg::LEVEL_W-1:0]  peak;
        logic [lpl_pkg::LEVEL_W-1:0]  peak1;
        logic [lpl_pkg::COEF_W-1:0]   pole;
        logic [63:0]                  mix;
        logic [63:0]                  gain;
        logic [$clog2(DEPTH)-1:0]     rd_pos;
        lpl_pkg::t_result             word;
        two   = chan_sel >= 2'd2;
        mag0  = f.sample_ch0[lpl_pkg::SAMPLE_W-1] ? -f.sample_ch0 : f.sample_ch0;
        mag1  = f.sample_ch1[lpl_pkg::SAMPLE_W-1] ? -f.sample_ch1 : f.sample_ch1;
        peak  = {mag0, 1'b0};
        peak1 = {mag1, 1'b0};
        if (two && peak1 > peak)
            peak = peak1;
        if (peak < thr_level)
            peak = thr_level;
        if (int'(hold_count) + 1 >= int'(hold_len) || peak > held_level) begin
            hold_count = '0;
            held_level = peak;
        end else begin
            hold_count = hold_count + 1'b1;
        end
        pole = (held_level > env_level) ? attack_pole : release_pole;
        mix = 64'(pole) * 64'(env_level) + (64'd65536 - 64'(pole)) * 64'(held_level)
            + 64'd32768;
        env_level = mix[16 +: lpl_pkg::LEVEL_W];
        gain = (64'(thr_level) << 16) / ((env_level == '0) ? 64'd1 : 64'(env_level));
        rd_pos = wr_pos - hold_len;
        word.limited_ch0   = apply_gain(line0[rd_pos], gain);
        word.limited_ch1   = two ? apply_gain(line1[rd_pos], gain) : '0;
        word.block_end_out = f.block_end;
        line0[wr_pos] = f.sample_ch0;
        if (two)
            line1[wr_pos] = f.sample_ch1;
        wr_pos = wr_pos + 1'b1;
        limited_words = {limited_words, word};
    endtask

    function automatic logic signed [lpl_pkg::SAMPLE_W-1:0] pick_sample(input t_signal style);
        case (style)
            SIG_SILENT:   return '0;
            SIG_QUIET:    return 16'(int'($urandom_range(0, 511)) - 256);
            SIG_MODERATE: return 16'(int'($urandom_range(0, 32767)) - 16384);
            SIG_EXTREME: begin
                case ($urandom_range(0, 4))
                    0:       return 16'sd32767;
                    1:       return -16'sd32768;
                    2:       return -16'sd32767;
                    3:       return 16'sd1;
                    default: return -16'sd1;
                endcase
            end
            default:      return 16'($urandom);
        endcase
    endfunction

    task automatic queue_frame(input logic signed [lpl_pkg::SAMPLE_W-1:0] s0,
                               input logic signed [lpl_pkg::SAMPLE_W-1:0] s1,
                               input logic be);
        lpl_pkg::t_frame f;
        f.sample_ch0 = s0;
        f.sample_ch1 = s1;
        f.block_end  = be;
        pending_frames = {pending_frames, f};
        frames_queued++;
    endtask

    // Runs of one signal style give the hold timer and envelope real attacks and decays.
    task automatic queue_program(input int count);
        t_signal                             style;
        int                                  run;
        int                                  n;
        logic signed [lpl_pkg::SAMPLE_W-1:0] s0;
        logic signed [lpl_pkg::SAMPLE_W-1:0] s1;
        n = 0;
        while (n < count) begin
            style = t_signal'($urandom_range(0, 4));
            run   = $urandom_range(1, 24);
            for (int k = 0; k < run && n < count; k++) begin
                s0 = pick_sample(style);
                case ($urandom_range(0, 3))
                    0:       s1 = s0;
                    1:       s1 = -s0;
                    default: s1 = pick_sample(style);
                endcase
                queue_frame(s0, s1, $urandom_range(0, 7) == 0);
                n++;
            end
        end
    endtask

    task automatic wait_drained();
        @(posedge i_clk);
        while (frames_accepted < frames_queued || limited_words.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [lpl_pkg::CFG_IDX_W-1:0] idx,
                             input logic [lpl_pkg::CFG_DATA_W-1:0] val);
        cfg_bus.valid <= 1'b1;
        cfg_bus.data  <= '{reg_index: idx, reg_data: val};
        @(posedge i_clk);
        while (!cfg_bus.ready)
            @(posedge i_clk);
        case (idx)
            lpl_pkg::CFG_THRESHOLD: thr_level    = val[lpl_pkg::LEVEL_W-1:0];
            lpl_pkg::CFG_HOLD:      hold_len     = val[lpl_pkg::HOLD_W-1:0];
            lpl_pkg::CFG_ATTACK:    attack_pole  = val[lpl_pkg::COEF_W-1:0];
            lpl_pkg::CFG_RELEASE:   release_pole = val[lpl_pkg::COEF_W-1:0];
            lpl_pkg::CFG_CHANNELS:  chan_sel     = val[lpl_pkg::CHAN_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(input logic [lpl_pkg::LEVEL_W-1:0] thr,
                                  input logic [lpl_pkg::HOLD_W-1:0] hold,
                                  input logic [lpl_pkg::COEF_W-1:0] atk,
                                  input logic [lpl_pkg::COEF_W-1:0] rel,
                                  input logic [lpl_pkg::CHAN_W-1:0] chans);
        write_reg(CFG_FIRST_UNUSED + 3'($urandom_range(0, 2)), 17'($urandom));
        write_reg(lpl_pkg::CFG_THRESHOLD, thr);
        write_reg(lpl_pkg::CFG_HOLD, lpl_pkg::CFG_DATA_W'(hold));
        write_reg(lpl_pkg::CFG_ATTACK, lpl_pkg::CFG_DATA_W'(atk));
        write_reg(lpl_pkg::CFG_RELEASE, lpl_pkg::CFG_DATA_W'(rel));
        write_reg(lpl_pkg::CFG_CHANNELS, lpl_pkg::CFG_DATA_W'(chans));
        cfg_bus.valid <= 1'b0;
        settings_applied++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            frame_bus.valid <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end else begin
            if (frame_bus.valid && frame_bus.ready) begin
                compute_limited(frame_bus.data);
                frames_accepted++;
            end
            if (!frame_bus.valid || frame_bus.ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    frame_bus.valid <= 1'b0;
                end else if (pending_frames.size() > 0) begin
                    frame_bus.valid <= 1'b1;
                    frame_bus.data  <= pending_frames.pop_front();
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 12);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    frame_bus.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            result_bus.ready <= 1'b0;
            rx_mode  = RX_OPEN;
            rx_count = 0;
        end else begin
            if (result_bus.valid && result_bus.ready) begin
                results_seen++;
                if (limited_words.size() == 0) begin
                    $error("result word with none expected: %p", result_bus.data);
                    err_count++;
                end else begin
                    due_word = limited_words.pop_front();
                    if (result_bus.data.limited_ch0 !== due_word.limited_ch0) begin
                        $error("limited_ch0: expected %0d, actual %0d",
                               due_word.limited_ch0, result_bus.data.limited_ch0);
                        err_count++;
                    end
                    if (result_bus.data.limited_ch1 !== due_word.limited_ch1) begin
                        $error("limited_ch1: expected %0d, actual %0d",
                               due_word.limited_ch1, result_bus.data.limited_ch1);
                        err_count++;
                    end
                    if (result_bus.data.block_end_out !== due_word.block_end_out) begin
                        $error("block_end_out: expected %0d, actual %0d",
                               due_word.block_end_out, result_bus.data.block_end_out);
                        err_count++;
                    end
                end
            end
            rx_count++;
            if (rx_count >= 97) begin
                rx_count = 0;
                rx_mode  = t_rx_mode'($urandom_range(0, 3));
            end
            case (rx_mode)
                RX_OPEN:   result_bus.ready <= 1'b1;
                RX_SPARSE: result_bus.ready <= $urandom_range(0, 3) != 0;
                RX_COIN:   result_bus.ready <= $urandom_range(0, 1) != 0;
                default:   result_bus.ready <= (rx_count % 32) >= 20;
            endcase
        end
    end

    initial begin
        logic [lpl_pkg::LEVEL_W-1:0] thr;
        logic [lpl_pkg::HOLD_W-1:0]  hold;
        i_rst_n       <= 1'b0;
        cfg_bus.valid <= 1'b0;
        cfg_bus.data  <= '0;
        thr_level    = lpl_pkg::THRESHOLD_RST;
        hold_len     = lpl_pkg::HOLD_RST;
        attack_pole  = lpl_pkg::ATTACK_RST;
        release_pole = lpl_pkg::RELEASE_RST;
        chan_sel     = lpl_pkg::CHANNELS_RST;
        hold_count   = '0;
        held_level   = lpl_pkg::THRESHOLD_RST;
        env_level    = lpl_pkg::THRESHOLD_RST;
        wr_pos       = '0;
        for (int k = 0; k < DEPTH; k++) begin
            line0[k] = '0;
            line1[k] = '0;
        end
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        queue_frame(16'sd32767, -16'sd32768, 1'b0);
        queue_frame(-16'sd32768, 16'sd32767, 1'b1);
        queue_frame(16'sd0, 16'sd0, 1'b0);
        queue_frame(16'sd1, -16'sd1, 1'b1);
        queue_frame(-16'sd1, 16'sd1, 1'b0);
        queue_frame(16'sd32767, 16'sd32767, 1'b0);
        queue_frame(-16'sd32768, -16'sd32768, 1'b1);
        queue_frame(16'sd16384, -16'sd16384, 1'b0);
        queue_frame(-16'sd16385, 16'sd16383, 1'b0);
        queue_frame(16'sd21845, -16'sd21846, 1'b1);
        queue_frame(16'sd0, 16'sd32767, 1'b0);
        queue_frame(-16'sd32768, 16'sd0, 1'b0);
        for (int k = 0; k < 10; k++)
            queue_frame(16'sd0, 16'sd0, k[0]);
        queue_program(130);
        wait_drained();

        apply_settings(17'd1, 10'd0, 16'd0, 16'd0, 2'd1);
        queue_program(120);
        wait_drained();
        apply_settings(17'd131071, 10'd1023, 16'd65535, 16'd65535, 2'd2);
        queue_program(120);
        wait_drained();
        apply_settings(17'd0, 10'd3, 16'd30000, 16'd0, 2'd0);
        queue_program(120);
        wait_drained();
        apply_settings(17'd40000, 10'd7, 16'd50000, 16'd64000, 2'd3);
        queue_program(120);
        wait_drained();

        for (int p = 0; p < 5; p++) begin
            thr = ($urandom_range(0, 3) == 0) ? 17'($urandom_range(1, 131071))
                                              : 17'($urandom_range(8192, 70000));
            case ($urandom_range(0, 5))
                0, 1, 2: hold = 10'($urandom_range(0, 16));
                3, 4:    hold = 10'($urandom_range(17, 128));
                default: hold = 10'($urandom_range(129, 1023));
            endcase
            apply_settings(thr, hold, 16'($urandom),
                           ($urandom_range(0, 1) != 0) ? 16'($urandom_range(60000, 65535))
                                                       : 16'($urandom),
                           2'($urandom_range(1, 2)));
            queue_program(120);
            wait_drained();
        end

        repeat (40) @(posedge i_clk);
        $display("Sent %0d frames under %0d register settings and checked %0d result words.",
                 frames_accepted, settings_applied + 1, results_seen);
        $display("Settings spanned one and two channels, zero and full hold, zero threshold.");
        if (err_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_CYCLES * 2 * HALF_PERIOD);
        $display("Verification failed");
        $finish;
    end

endmodule
